### design/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;

    localparam int HDR_BYTES         = 4;
    localparam int HDR_SHIFT         = $clog2(HDR_BYTES);
    localparam int SMALL_BLOCK_BYTES = 16;
    localparam int SMALL_BLOCK_COUNT = 32;
    localparam int SMALL_SZ  = ((SMALL_BLOCK_BYTES + HDR_BYTES - 1) / HDR_BYTES) * HDR_BYTES;
    localparam int MIN_SPLIT = ((2 * HDR_BYTES + HDR_BYTES - 1) / HDR_BYTES) * HDR_BYTES;
    localparam int BUCKET_BYTES = SMALL_SZ * SMALL_BLOCK_COUNT;
    localparam int BARRIER_IDX  = BUCKET_BYTES / HDR_BYTES;
    localparam int WILD_IDX     = BARRIER_IDX + 1;
    localparam int LEN_W        = 15;
    localparam int SIZE_W       = 17;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_KICK  = 2'd2,
        REQ_CHECK = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NOFIT   = 2'd1,
        STAT_BADFREE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_LOOK,
        S_SPLIT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_req_type   req_type;
        logic [15:0] request_size;
        logic [15:0] data_address;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [15:0] granted_address;
        logic        address_in_use;
    } t_result;

endpackage
`default_nettype wire

### design/ffha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface ffha_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] request_size;
    logic [15:0] data_address;

    modport source (output valid, req_type, request_size, data_address, input ready);
    modport sink   (input valid, req_type, request_size, data_address, output ready);
endinterface

interface ffha_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] granted_address;
    logic        address_in_use;

    modport source (output valid, status, granted_address, address_in_use, input ready);
    modport sink   (input valid, status, granted_address, address_in_use, output ready);
endinterface
`default_nettype wire

### design/ffha_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [15:0]   i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // same-address write wins over the stored word
    always_ff @(posedge i_clk) begin
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### design/ffha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl #(
    parameter int HEAP_BYTES = 2048,
    parameter int NSLOTS     = 512,
    parameter int IW         = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire ffha_pkg::t_request i_req,
    output logic                   o_req_ready,
    output logic                   o_res_valid,
    input  wire logic              i_res_ready,
    output ffha_pkg::t_result      o_result,
    output logic                   o_we,
    output logic [IW-1:0]          o_waddr,
    output logic [15:0]            o_wdata,
    output logic [IW-1:0]          o_raddr,
    input  wire logic [15:0]       i_rdata
);
    import ffha_pkg::*;

    localparam int WILD_BYTES = HEAP_BYTES - BUCKET_BYTES - 2 * HDR_BYTES;
    localparam logic [15:0]   NSLOTS_W    = 16'(NSLOTS);
    localparam logic [15:0]   HEAP_W      = 16'(HEAP_BYTES);
    localparam logic [15:0]   WILD_IDX_W  = 16'(WILD_IDX);
    localparam logic [15:0]   BARRIER_W   = 16'(BARRIER_IDX);
    localparam logic [IW-1:0] END_IDX     = IW'(NSLOTS - 1);
    localparam logic [IW:0]   ITER_MAX    = (IW + 1)'(NSLOTS);
    localparam logic [15:0]   BUCKET_HDR  = 16'(BUCKET_BYTES & 32'h7FFF);
    localparam logic [15:0]   BARRIER_HDR = 16'(HDR_BYTES) | 16'h8000;
    localparam logic [15:0]   WILD_HDR    = 16'(WILD_BYTES & 32'h7FFF);

    t_state              r_state, n_state;
    logic [IW-1:0]       r_clr, n_clr;
    t_req_type           r_type, n_type;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_prev, n_prev;
    logic [LEN_W-1:0]    r_prev_len, n_prev_len;
    logic                r_coal, n_coal;
    logic                r_first, n_first;
    logic [IW:0]         r_iter, n_iter;
    logic [IW-1:0]       r_ff, n_ff;
    logic                r_kicked, n_kicked;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic [15:0]         r_rem_idx, n_rem_idx;
    t_status             r_status, n_status;
    logic [15:0]         r_granted, n_granted;
    logic                r_inuse, n_inuse;

    logic [15:0]         init_hdr;
    logic [SIZE_W-1:0]   req_bytes, req_round;
    logic [15:0]         start_w, addr_tmp;
    logic                addr_ok;
    logic [IW-1:0]       addr_slot;
    logic [LEN_W-1:0]    v_len, pl, f_len, rem, newlen;
    logic [IW-1:0]       f_idx;
    logic                found, split;
    logic [15:0]         nidx, ff_t;

    always_comb begin
        if ({{(16 - IW){1'b0}}, r_clr} == WILD_IDX_W) begin
            init_hdr = WILD_HDR;
        end else if ({{(16 - IW){1'b0}}, r_clr} == BARRIER_W) begin
            init_hdr = BARRIER_HDR;
        end else if (r_clr == '0) begin
            init_hdr = BUCKET_HDR;
        end else begin
            init_hdr = '0;
        end
    end

    assign req_bytes = (i_req.req_type == REQ_KICK) ? SIZE_W'(1) : {1'b0, i_req.request_size};
    assign req_round = (req_bytes + SIZE_W'(2 * HDR_BYTES - 1)) & ~SIZE_W'(HDR_BYTES - 1);
    assign start_w   = (req_round <= SIZE_W'(SMALL_SZ)) ? 16'(r_ff) : WILD_IDX_W;
    assign addr_ok   = (i_req.data_address >= 16'(HDR_BYTES)) && (i_req.data_address < HEAP_W)
                       && (i_req.data_address[HDR_SHIFT-1:0] == '0);
    assign addr_tmp  = (i_req.data_address >> HDR_SHIFT) - 16'd1;
    assign addr_slot = addr_tmp[IW-1:0];
    assign v_len     = i_rdata[LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_clr    <= '0;
            r_ff     <= '0;
            r_kicked <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ff     <= n_ff;
            r_kicked <= n_kicked;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type     <= n_type;
        r_size     <= n_size;
        r_idx      <= n_idx;
        r_prev     <= n_prev;
        r_prev_len <= n_prev_len;
        r_coal     <= n_coal;
        r_first    <= n_first;
        r_iter     <= n_iter;
        r_rem      <= n_rem;
        r_rem_idx  <= n_rem_idx;
        r_status   <= n_status;
        r_granted  <= n_granted;
        r_inuse    <= n_inuse;
    end

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_type     = r_type;
        n_size     = r_size;
        n_idx      = r_idx;
        n_prev     = r_prev;
        n_prev_len = r_prev_len;
        n_coal     = r_coal;
        n_first    = r_first;
        n_iter     = r_iter;
        n_ff       = r_ff;
        n_kicked   = r_kicked;
        n_rem      = r_rem;
        n_rem_idx  = r_rem_idx;
        n_status   = r_status;
        n_granted  = r_granted;
        n_inuse    = r_inuse;
        o_we        = 1'b0;
        o_waddr     = r_idx;
        o_wdata     = '0;
        o_raddr     = r_idx;
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        pl     = '0;
        f_len  = '0;
        f_idx  = r_idx;
        rem    = '0;
        newlen = '0;
        found  = 1'b0;
        split  = 1'b0;
        nidx   = '0;
        ff_t   = '0;

        unique case (r_state)
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = init_hdr;
                n_clr   = r_clr + 1'b1;
                if (r_clr == END_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_type    = i_req.req_type;
                    n_size    = req_round;
                    n_status  = STAT_OK;
                    n_granted = '0;
                    n_inuse   = 1'b0;
                    n_coal    = 1'b0;
                    n_first   = 1'b1;
                    n_iter    = '0;
                    if (i_req.req_type == REQ_ALLOC || i_req.req_type == REQ_KICK) begin
                        if (start_w >= NSLOTS_W) begin
                            n_status = STAT_NOFIT;
                            n_state  = S_RESP;
                        end else begin
                            o_raddr = start_w[IW-1:0];
                            n_idx   = start_w[IW-1:0];
                            n_state = S_WALK;
                        end
                    end else if (!addr_ok) begin
                        if (i_req.req_type == REQ_FREE) begin
                            n_status = STAT_BADFREE;
                        end
                        n_state = S_RESP;
                    end else begin
                        o_raddr = addr_slot;
                        n_idx   = addr_slot;
                        n_state = S_LOOK;
                    end
                end
            end
            S_WALK: begin
                if (!r_first && i_rdata == 16'd0) begin
                    n_status = STAT_NOFIT;
                    n_state  = S_RESP;
                end else begin
                    if (i_rdata[15]) begin
                        n_coal = 1'b0;
                    end else if (r_coal) begin
                        // fold this free block into the one before it
                        pl         = r_prev_len + v_len;
                        o_we       = 1'b1;
                        o_waddr    = r_prev;
                        o_wdata    = {1'b0, pl};
                        n_prev_len = pl;
                        if ({2'b00, pl} >= r_size) begin
                            found = 1'b1;
                            f_idx = r_prev;
                            f_len = pl;
                        end
                    end else if ({2'b00, v_len} >= r_size) begin
                        found = 1'b1;
                        f_idx = r_idx;
                        f_len = v_len;
                    end else begin
                        n_coal     = 1'b1;
                        n_prev     = r_idx;
                        n_prev_len = v_len;
                    end

                    if (found) begin
                        rem       = f_len - r_size[LEN_W-1:0];
                        split     = (rem >= LEN_W'(MIN_SPLIT));
                        newlen    = split ? r_size[LEN_W-1:0] : f_len;
                        o_we      = 1'b1;
                        o_waddr   = f_idx;
                        o_wdata   = {(r_type != REQ_KICK), newlen};
                        n_idx     = f_idx;
                        n_rem     = rem;
                        n_rem_idx = 16'(f_idx) + 16'(r_size >> HDR_SHIFT);
                        if (r_type == REQ_KICK) begin
                            n_ff     = f_idx;
                            n_kicked = 1'b1;
                        end else begin
                            n_granted = (16'(f_idx) + 16'd1) << HDR_SHIFT;
                            if (r_kicked && r_ff == f_idx) begin
                                ff_t = 16'(f_idx) + 16'(newlen >> HDR_SHIFT);
                                n_ff = (ff_t >= NSLOTS_W) ? END_IDX : ff_t[IW-1:0];
                            end
                        end
                        n_state = split ? S_SPLIT : S_RESP;
                    end else begin
                        nidx = 16'(r_idx) + 16'(v_len >> HDR_SHIFT);
                        if (nidx >= NSLOTS_W || r_iter == ITER_MAX) begin
                            n_status = STAT_NOFIT;
                            n_state  = S_RESP;
                        end else begin
                            o_raddr = nidx[IW-1:0];
                            n_idx   = nidx[IW-1:0];
                            n_iter  = r_iter + 1'b1;
                            n_first = 1'b0;
                        end
                    end
                end
            end
            S_SPLIT: begin
                if (r_rem_idx < NSLOTS_W) begin
                    o_we    = 1'b1;
                    o_waddr = r_rem_idx[IW-1:0];
                    o_wdata = {1'b0, r_rem};
                end
                n_state = S_RESP;
            end
            S_LOOK: begin
                if (r_type == REQ_FREE) begin
                    if (i_rdata[15]) begin
                        o_we    = 1'b1;
                        o_waddr = r_idx;
                        o_wdata = {1'b0, v_len};
                        if (r_ff > r_idx) begin
                            n_ff = r_idx;
                        end
                    end else begin
                        n_status = STAT_BADFREE;
                    end
                end else begin
                    n_inuse = i_rdata[15];
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    assign o_result = '{status: r_status, granted_address: r_granted, address_in_use: r_inuse};

endmodule
`default_nettype wire

### design/first_fit_heap_allocator.sv
// First-fit heap manager over a header store of HEAP_BYTES/4 16-bit headers held in one
// synchronous RAM. After reset a clearing pass writes the initial layout (small-block bucket,
// barrier, wilderness, end marker), during which no request is taken. Free and check read
// the header at the given address and then give their result; a misaligned address or one
// outside the heap skips the read. Allocate and kick visit one header per cycle, walking
// until a fit or the end of the heap is found, and a split block gets its remainder header
// written in a separate step; the single RAM read port sets that pace. One request is worked
// at a time; a new one is taken while the previous result waits in the output register.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES = 2048
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    ffha_req_if.sink  i_req,
    ffha_rsp_if.source o_rsp
);
    import ffha_pkg::*;

    localparam int NSLOTS = HEAP_BYTES / HDR_BYTES;
    localparam int IW     = $clog2(NSLOTS);

    t_request      req;
    t_result       result;
    t_result       r_out;
    logic          r_out_valid;
    logic          res_valid, res_ready;
    logic          mem_we;
    logic [IW-1:0] mem_waddr, mem_raddr;
    logic [15:0]   mem_wdata, mem_rdata;

    assign req = '{req_type: t_req_type'(i_req.req_type),
                   request_size: i_req.request_size,
                   data_address: i_req.data_address};

    ffha_mem #(.DEPTH(NSLOTS), .AW(IW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    ffha_ctrl #(.HEAP_BYTES(HEAP_BYTES), .NSLOTS(NSLOTS), .IW(IW)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req       (req),
        .o_req_ready (i_req.ready),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_result    (result),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_raddr     (mem_raddr),
        .i_rdata     (mem_rdata)
    );

    assign res_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= result;
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.granted_address = r_out.granted_address;
    assign o_rsp.address_in_use  = r_out.address_in_use;

endmodule
`default_nettype wire

### design/ffha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ffha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        rsp_valid,
    input wire logic [1:0]  rsp_status,
    input wire logic [15:0] rsp_granted,
    input wire logic        rsp_in_use
);
    import ffha_pkg::*;

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !rsp_valid)
        else $error("result shown right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_status == STAT_OK || rsp_status == STAT_NOFIT
                       || rsp_status == STAT_BADFREE))
        else $error("undefined status code");

    a_fail_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_status != STAT_OK) |-> (rsp_granted == 16'd0 && !rsp_in_use))
        else $error("failed request carries a grant or in-use flag");

    a_grant_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> (rsp_granted[HDR_SHIFT-1:0] == '0))
        else $error("granted address not header aligned");

    a_check_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp_valid && rsp_in_use) |-> (rsp_granted == 16'd0))
        else $error("check result carries a grant");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .rsp_valid   (o_rsp.valid),
    .rsp_status  (o_rsp.status),
    .rsp_granted (o_rsp.granted_address),
    .rsp_in_use  (o_rsp.address_in_use)
);
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import ffha_pkg::*;

    localparam int HEAP      = 2048;
    localparam int NSLOTS    = HEAP / HDR_BYTES;
    localparam int END_IDX   = NSLOTS - 1;
    localparam int WILD_LEN  = HEAP - BUCKET_BYTES - 2 * HDR_BYTES;
    localparam int STALL_MAX = 20000;

    logic i_clk;
    logic i_rst_n;

    ffha_req_if req_ch ();
    ffha_rsp_if rsp_ch ();

    first_fit_heap_allocator #(.HEAP_BYTES(HEAP)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // shadow heap state
    logic [15:0] hdr_mem [NSLOTS];
    int          ff_idx;
    bit          kicked;

    t_request    pending_reqs [$];
    t_result     awaited_results [$];
    logic [15:0] live_addrs [$];

    int  n_mismatch;
    int  n_checked;
    int  n_alloc_ok;
    int  n_nofit;
    int  n_badfree;
    int  n_inuse;
    int  idle_cycles;
    bit  no_idle;
    bit  stim_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int hdr_rd(int i);
        return (i < NSLOTS) ? int'(hdr_mem[i]) : 0;
    endfunction

    function automatic void hdr_wr(int i, int v);
        if (i < NSLOTS) hdr_mem[i] = v[15:0];
    endfunction

    function automatic void heap_reset();
        for (int i = 0; i < NSLOTS; i++) hdr_mem[i] = '0;
        hdr_mem[0]           = BUCKET_BYTES[15:0] & 16'h7FFF;
        hdr_mem[BARRIER_IDX] = HDR_BYTES[15:0] | 16'h8000;
        hdr_mem[WILD_IDX]    = WILD_LEN[15:0];
        ff_idx = 0;
        kicked = 1'b0;
    endfunction

    function automatic void move_ff(int i);
        ff_idx = (i < NSLOTS) ? i : END_IDX;
    endfunction

    // first-fit walk with merging; returns header slot or -1
    function automatic int heap_alloc(int req);
        int size, idx, prev, len, v, rem, pl;
        bit merging, found;
        size = ((req + HDR_BYTES + HDR_BYTES - 1) / HDR_BYTES) * HDR_BYTES;
        idx = (size <= SMALL_SZ) ? ff_idx : WILD_IDX;
        prev = 0;
        merging = 0;
        found = 0;
        for (int it = 0; it <= NSLOTS; it++) begin
            if (idx >= NSLOTS) break;
            v = hdr_mem[idx];
            len = v & 16'h7FFF;
            if (v[15]) begin
                merging = 0;
            end else if (merging) begin
                pl = ((hdr_rd(prev) & 16'h7FFF) + len) & 16'h7FFF;
                hdr_wr(prev, pl);
                if (pl >= size) begin
                    idx = prev;
                    found = 1;
                    break;
                end
            end else begin
                if (len >= size) begin
                    found = 1;
                    break;
                end
                merging = 1;
                prev = idx;
            end
            idx += len / HDR_BYTES;
            if (idx >= NSLOTS || hdr_mem[idx] == 16'h0) break;
        end
        if (!found) return -1;
        len = hdr_rd(idx) & 16'h7FFF;
        rem = len - size;
        if (rem >= MIN_SPLIT) begin
            hdr_wr(idx + size / HDR_BYTES, rem);
            hdr_wr(idx, size | 16'h8000);
        end else begin
            hdr_wr(idx, hdr_rd(idx) | 16'h8000);
        end
        if (kicked && ff_idx == idx)
            move_ff(idx + (hdr_rd(idx) & 16'h7FFF) / HDR_BYTES);
        return idx;
    endfunction

    function automatic int slot_of(int addr);
        if (addr < HDR_BYTES || addr >= HEAP || (addr % HDR_BYTES) != 0) return NSLOTS;
        return addr / HDR_BYTES - 1;
    endfunction

    function automatic void release_slot(int s);
        hdr_wr(s, hdr_rd(s) & 16'h7FFF);
        if (ff_idx > s) ff_idx = s;
    endfunction

    function automatic t_result predict_heap(t_request r);
        t_result res;
        int s;
        res = '{status: STAT_OK, granted_address: 16'h0, address_in_use: 1'b0};
        case (r.req_type)
            REQ_ALLOC: begin
                s = heap_alloc(int'(r.request_size));
                if (s >= 0) res.granted_address = 16'((s + 1) * HDR_BYTES);
                else res.status = STAT_NOFIT;
            end
            REQ_FREE: begin
                s = slot_of(int'(r.data_address));
                if (s < NSLOTS && hdr_mem[s][15]) release_slot(s);
                else res.status = STAT_BADFREE;
            end
            REQ_KICK: begin
                s = heap_alloc(1);
                if (s >= 0) begin
                    move_ff(s);
                    release_slot(s);
                    kicked = 1'b1;
                end else begin
                    res.status = STAT_NOFIT;
                end
            end
            default: begin
                s = slot_of(int'(r.data_address));
                if (s < NSLOTS && hdr_mem[s][15]) res.address_in_use = 1'b1;
            end
        endcase
        return res;
    endfunction

    function automatic void push_req(t_req_type t, int sz, int ad);
        t_request r;
        r.req_type = t;
        r.request_size = sz[15:0];
        r.data_address = ad[15:0];
        pending_reqs.push_back(r);
    endfunction

    function automatic logic [15:0] pick_addr();
        if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0)
            return 16'($urandom_range(0, 65535));
        return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_ch.ready) begin
            if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 22)) begin
                t_request r;
                r = pending_reqs.pop_front();
                req_ch.valid        <= 1'b1;
                req_ch.req_type     <= r.req_type;
                req_ch.request_size <= r.request_size;
                req_ch.data_address <= r.data_address;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            t_request r;
            t_result  e;
            r.req_type     = t_req_type'(req_ch.req_type);
            r.request_size = req_ch.request_size;
            r.data_address = req_ch.data_address;
            e = predict_heap(r);
            awaited_results.push_back(e);
            if (r.req_type == REQ_ALLOC && e.status == STAT_OK) begin
                live_addrs.push_back(e.granted_address);
                n_alloc_ok++;
            end
            if (r.req_type == REQ_FREE && e.status == STAT_OK) begin
                foreach (live_addrs[k])
                    if (live_addrs[k] == r.data_address) begin
                        live_addrs.delete(k);
                        break;
                    end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 22);
            if (rsp_ch.valid && rsp_ch.ready) begin
                t_result e;
                n_checked++;
                if (awaited_results.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("unexpected result: status=%0d addr=%h inuse=%0d",
                                 rsp_ch.status, rsp_ch.granted_address,
                                 rsp_ch.address_in_use);
                end else begin
                    e = awaited_results.pop_front();
                    if (e.status == STAT_NOFIT) n_nofit++;
                    if (e.status == STAT_BADFREE) n_badfree++;
                    if (e.address_in_use) n_inuse++;
                    if (rsp_ch.status !== e.status
                        || rsp_ch.granted_address !== e.granted_address
                        || rsp_ch.address_in_use !== e.address_in_use) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch #%0d: exp st=%0d addr=%h inuse=%0d, got st=%0d addr=%h inuse=%0d",
                                     n_checked, e.status, e.granted_address,
                                     e.address_in_use, rsp_ch.status,
                                     rsp_ch.granted_address, rsp_ch.address_in_use);
                    end
                end
            end
        end
    end

    // watchdog: clearing pass plus longest walk stays far below this
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("watchdog expired");
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int op;
        heap_reset();
        n_mismatch = 0; n_checked = 0; n_alloc_ok = 0; n_nofit = 0;
        n_badfree = 0; n_inuse = 0; idle_cycles = 0;
        no_idle = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = '0;
        req_ch.request_size = '0;
        req_ch.data_address = '0;
        rsp_ch.ready = 1'b0;

        // directed: size extremes, every request kind, bad frees, kick
        push_req(REQ_ALLOC, 0, 0);
        push_req(REQ_ALLOC, 12, 0);
        push_req(REQ_ALLOC, 13, 0);
        push_req(REQ_ALLOC, 65535, 16'hFFFF);
        push_req(REQ_ALLOC, 1000, 0);
        push_req(REQ_CHECK, 0, 4);
        push_req(REQ_CHECK, 0, 6);
        push_req(REQ_CHECK, 0, 65535);
        push_req(REQ_CHECK, 0, BUCKET_BYTES + HDR_BYTES);
        push_req(REQ_FREE, 0, 0);
        push_req(REQ_FREE, 0, 2);
        push_req(REQ_FREE, 0, HEAP);
        push_req(REQ_FREE, 0, 8);
        push_req(REQ_FREE, 0, 4);
        push_req(REQ_FREE, 0, 4);
        push_req(REQ_ALLOC, WILD_LEN - HDR_BYTES, 0);
        push_req(REQ_ALLOC, WILD_LEN - HDR_BYTES - 6, 0);
        push_req(REQ_KICK, 0, 0);
        push_req(REQ_ALLOC, 4, 0);
        push_req(REQ_ALLOC, 8, 0);
        push_req(REQ_KICK, 16'hFFFF, 16'hFFFF);
        push_req(REQ_CHECK, 16'hFFFF, 8);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < 1880; n++) begin
            while (pending_reqs.size() > 8) @(posedge i_clk);
            // drain so live-address picks track the shadow heap
            while (awaited_results.size() != 0 || req_ch.valid) @(posedge i_clk);
            no_idle = (n >= 600 && n < 900);
            op = $urandom_range(0, 99);
            if (op < 45) begin
                if ($urandom_range(0, 9) < 7)
                    push_req(REQ_ALLOC, $urandom_range(0, 12), $urandom_range(0, 65535));
                else if ($urandom_range(0, 9) < 9)
                    push_req(REQ_ALLOC, $urandom_range(13, 400), $urandom_range(0, 65535));
                else
                    push_req(REQ_ALLOC, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else if (op < 80) begin
                push_req(REQ_FREE, $urandom_range(0, 65535), pick_addr());
            end else if (op < 85) begin
                push_req(REQ_KICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
            end else begin
                push_req(REQ_CHECK, $urandom_range(0, 65535), pick_addr());
            end
        end
        stim_done = 1'b1;
        while (pending_reqs.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (HEAP / HDR_BYTES + 10) @(posedge i_clk);

        $display("checked %0d results: %0d grants, %0d no-fit, %0d bad frees, %0d in-use checks",
                 n_checked, n_alloc_ok, n_nofit, n_badfree, n_inuse);
        $display("mismatches: %0d", n_mismatch);
        if (n_mismatch == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
